// File: sv/kfenv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfenv_pkg
// Shared widths, types and codes of the keyframe envelope generator.
// ----------------------------------------------------------------------------
package kfenv_pkg;

	localparam int TIME_W   = 24;
	localparam int LEVEL_W  = 16;
	localparam int CMD_W    = 2;
	localparam int RTRIG_W  = 2;
	localparam int CFG_W    = 2;

	// divider operand widths: |dlevel * dtime| and a time span
	localparam int DIVIDEND_W = 40;
	localparam int DIVISOR_W  = TIME_W;

	localparam int KEY_SLOTS_DEF   = 16;
	localparam int VOICE_COUNT_DEF = 4;

	typedef logic [TIME_W-1:0]         time_t;
	typedef logic signed [LEVEL_W-1:0] level_t;
	typedef logic [CMD_W-1:0]          cmd_t;

	// command codes
	localparam cmd_t CMD_ADD_KEY = 2'd0;
	localparam cmd_t CMD_TRIGGER = 2'd1;
	localparam cmd_t CMD_TICK    = 2'd2;
	localparam cmd_t CMD_STOP    = 2'd3;

	// retrigger modes
	localparam logic [RTRIG_W-1:0] RTRIG_OVERLAP = 2'd0;
	localparam logic [RTRIG_W-1:0] RTRIG_HOLD    = 2'd2;

	// blend modes
	localparam logic BLEND_SUM = 1'b0;

	// configuration register indexes
	localparam logic CFG_RETRIGGER = 1'b0;
	localparam logic CFG_BLEND     = 1'b1;

endpackage

// File: sv/kfenv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfenv_if
// Valid/ready channels carrying command words in and level words out.
// ----------------------------------------------------------------------------
interface kfenv_in_if;
	logic                 valid;
	logic                 ready;
	kfenv_pkg::cmd_t      cmd;
	kfenv_pkg::time_t     key_time;
	kfenv_pkg::level_t    key_value;
	kfenv_pkg::time_t     time_amount;

	modport source (output valid, cmd, key_time, key_value, time_amount, input ready);
	modport sink (input valid, cmd, key_time, key_value, time_amount, output ready);
endinterface

interface kfenv_out_if;
	logic                 valid;
	logic                 ready;
	kfenv_pkg::level_t    level;
	logic                 accepted;
	logic                 playing;

	modport source (output valid, level, accepted, playing, input ready);
	modport sink (input valid, level, accepted, playing, output ready);
endinterface

// File: sv/kfenv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfenv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfenv_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [kfenv_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [kfenv_pkg::DIVISOR_W-1:0]     divisor,
	output logic                                busy,
	output logic [kfenv_pkg::DIVIDEND_W-1:0]    quotient
);

	localparam int NW = kfenv_pkg::DIVIDEND_W;
	localparam int DW = kfenv_pkg::DIVISOR_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   shifted;
	logic          fits;

	// trial subtract of the next partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		fits    = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DW'(shifted - {1'b0, dsr_q});
			end else begin
				rem_q <= shifted[DW-1:0];
			end
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

// File: sv/keyframe_envelope_voices.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_envelope_voices
// Keyframe envelope generator: sorted key table, overlapping voices, blend.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries command words (add key, trigger, tick, stop); out_ch returns
//  one word per command: level, accepted flag and playing flag.
//  cfg_wr_en/cfg_index/cfg_data write retrigger mode (0) and blend mode (1);
//  write them only while the block is idle.
//  One command is worked at a time; in_ch.ready is high only when idle.
//  A single sequencer scans the key table through its registered read port,
//  with one shared divider for interpolation:
//    add key : moves each later key up one slot; rejected when the table is full
//    stop    : reads the last key and clears all voices
//    trigger : scans the voices (overlap) or restarts voice 0, evaluating
//              the curve first in hold mode
//    tick    : per active voice two curve evaluations and a key scan
//  The result word is held in an output register until taken; a stall on
//  out_ch simply keeps the block busy.
//  Reset empties the key table and clears all voices, level and hold state.
// ----------------------------------------------------------------------------
module keyframe_envelope_voices #(
	parameter int KEY_SLOTS   = kfenv_pkg::KEY_SLOTS_DEF,
	parameter int VOICE_COUNT = kfenv_pkg::VOICE_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	kfenv_in_if.sink                     in_ch,
	kfenv_out_if.source                  out_ch,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [kfenv_pkg::CFG_W-1:0]  cfg_data
);

	localparam int TW    = kfenv_pkg::TIME_W;
	localparam int LW    = kfenv_pkg::LEVEL_W;
	localparam int KA    = $clog2(KEY_SLOTS);
	localparam int KC    = $clog2(KEY_SLOTS + 1);
	localparam int VA    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int ACC_W = LW + $clog2(VOICE_COUNT) + 1;
	localparam int PW    = LW + 1 + TW + 1;
	localparam int NW    = kfenv_pkg::DIVIDEND_W;
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(2 ** (LW - 1) - 1);
	localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

	typedef enum logic [4:0] {
		S_IDLE, S_ADD_CHK, S_ADD_WAIT, S_ADD_USE, S_LAST_WAIT, S_LAST_USE,
		S_TG_SCAN, S_TG_START, S_TG_HOLD,
		S_CA_GO, S_CA_W0, S_CA_K0, S_CA_WI, S_CA_KI, S_CA_MUL, S_CA_DST, S_CA_DIV,
		S_TK_VOICE, S_TK_PK, S_PK_A, S_PK_B, S_PK_WAIT, S_PK_SCAN,
		S_TK_ACC, S_TK_NEXT, S_TK_FIN, S_OUT
	} state_t;

	// configuration
	logic [kfenv_pkg::RTRIG_W-1:0] rtrig_q;
	logic                          blend_q;

	// key table memory
	kfenv_pkg::time_t  key_tm_mem [KEY_SLOTS];
	kfenv_pkg::level_t key_lv_mem [KEY_SLOTS];
	kfenv_pkg::time_t  rd_tm_q;
	kfenv_pkg::level_t rd_lv_q;
	logic [KA-1:0]     addr_q;
	logic              wr_en;
	kfenv_pkg::time_t  wr_tm;
	kfenv_pkg::level_t wr_lv;

	// sequencer state
	state_t            state_q, ret_q;
	kfenv_pkg::cmd_t   cmd_q;
	kfenv_pkg::time_t  ktime_q, amt_q;
	kfenv_pkg::level_t kval_q;
	logic [KC-1:0]     key_total_q, idx_q;
	logic [KA-1:0]     i_q;
	logic              ok_q;

	// curve evaluation
	kfenv_pkg::time_t        ca_t_q, prev_tm_q, nxt_tm_q;
	kfenv_pkg::level_t       ca_res_q, prev_lv_q, nxt_lv_q;
	logic signed [PW-1:0]    prod_q;

	// peak and blend
	kfenv_pkg::time_t        pk_lo_q, pk_hi_q, last_tm_q;
	kfenv_pkg::level_t       peak_q, last_lv_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    any_q;

	// voices
	logic              v_act_q   [VOICE_COUNT];
	logic              v_fresh_q [VOICE_COUNT];
	kfenv_pkg::time_t  v_now_q   [VOICE_COUNT];
	kfenv_pkg::time_t  v_bef_q   [VOICE_COUNT];
	logic [VA-1:0]     vi_q, free_idx_q, best_idx_q;
	logic              free_found_q;

	// output and hold
	kfenv_pkg::level_t out_level_q, held_q;
	logic              holding_q;

	// divider
	logic              div_start, div_busy;
	logic [NW-1:0]     div_quo, div_dividend;
	kfenv_pkg::time_t  span;

	// helpers
	logic [KC-1:0]           tot_m1;
	logic                    is_full, tbl_empty, scan_last;
	logic [TW:0]             now_sum;
	kfenv_pkg::time_t        now_sat, cur_now, cur_bef;
	logic signed [LW:0]      dlev;
	logic signed [PW-1:0]    mag;
	logic signed [LW+1:0]    q_signed, interp;
	logic signed [ACC_W-1:0] peak_ext, acc_sum;
	kfenv_pkg::level_t       blend_lvl, acc_sat;
	logic [VA-1:0]           vsel;
	logic                    playing;

	// ------------------------------------------------------------------
	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtrig_q <= '0;
			blend_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kfenv_pkg::CFG_RETRIGGER: rtrig_q <= cfg_data;
				kfenv_pkg::CFG_BLEND:     blend_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// key table: one write port, one registered read port
	always_comb begin
		wr_en = (state_q == S_ADD_CHK && idx_q == '0) || state_q == S_ADD_USE;
		if (state_q == S_ADD_USE && rd_tm_q > ktime_q) begin
			wr_tm = rd_tm_q;
			wr_lv = rd_lv_q;
		end else begin
			wr_tm = ktime_q;
			wr_lv = kval_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_tm_mem[idx_q[KA-1:0]] <= wr_tm;
			key_lv_mem[idx_q[KA-1:0]] <= wr_lv;
		end
		rd_tm_q <= key_tm_mem[addr_q];
		rd_lv_q <= key_lv_mem[addr_q];
	end

	// ------------------------------------------------------------------
	// shared divider for segment interpolation
	always_comb begin
		mag          = prod_q[PW-1] ? -prod_q : prod_q;
		div_dividend = mag[NW-1:0];
		span         = nxt_tm_q - prev_tm_q;
		div_start    = state_q == S_CA_DST;
	end

	kfenv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (span),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// datapath helpers
	always_comb begin
		tot_m1    = key_total_q - KC'(1);
		is_full   = key_total_q == KC'(KEY_SLOTS);
		tbl_empty = key_total_q == '0;
		scan_last = KC'(i_q) == tot_m1;
		cur_now   = v_now_q[vi_q];
		cur_bef   = v_bef_q[vi_q];
		now_sum   = {1'b0, cur_now} + {1'b0, amt_q};
		now_sat   = now_sum[TW] ? '1 : now_sum[TW-1:0];
		dlev      = {nxt_lv_q[LW-1], nxt_lv_q} - {prev_lv_q[LW-1], prev_lv_q};
		q_signed  = prod_q[PW-1] ? -$signed({2'b00, div_quo[LW-1:0]})
		                         : $signed({2'b00, div_quo[LW-1:0]});
		interp    = {{2{prev_lv_q[LW-1]}}, prev_lv_q} + q_signed;
		peak_ext  = {{(ACC_W-LW){peak_q[LW-1]}}, peak_q};
		acc_sum   = acc_q + peak_ext;
		if (acc_q > ACC_MAX) begin
			acc_sat = kfenv_pkg::level_t'(ACC_MAX);
		end else if (acc_q < ACC_MIN) begin
			acc_sat = kfenv_pkg::level_t'(ACC_MIN);
		end else begin
			acc_sat = acc_q[LW-1:0];
		end
		blend_lvl = any_q ? acc_sat : last_lv_q;
		vsel      = free_found_q ? free_idx_q : best_idx_q;
		playing   = 1'b0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			playing = playing | v_act_q[v];
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			key_total_q  <= '0;
			out_level_q  <= '0;
			held_q       <= '0;
			holding_q    <= 1'b0;
			ok_q         <= 1'b0;
			addr_q       <= '0;
			vi_q         <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				v_act_q[v]   <= 1'b0;
				v_fresh_q[v] <= 1'b0;
				v_now_q[v]   <= '0;
				v_bef_q[v]   <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q   <= in_ch.cmd;
						ktime_q <= in_ch.key_time;
						kval_q  <= in_ch.key_value;
						amt_q   <= in_ch.time_amount;
						ok_q    <= 1'b1;
						unique case (in_ch.cmd)
							kfenv_pkg::CMD_ADD_KEY: begin
								idx_q <= key_total_q;
								if (is_full) begin
									ok_q    <= 1'b0;
									state_q <= S_OUT;
								end else begin
									state_q <= S_ADD_CHK;
								end
							end
							kfenv_pkg::CMD_TRIGGER: begin
								vi_q         <= '0;
								free_found_q <= 1'b0;
								best_idx_q   <= '0;
								if (rtrig_q == kfenv_pkg::RTRIG_OVERLAP) begin
									state_q <= S_TG_SCAN;
								end else if (rtrig_q == kfenv_pkg::RTRIG_HOLD) begin
									ca_t_q  <= in_ch.time_amount;
									ret_q   <= S_TG_HOLD;
									state_q <= S_CA_GO;
								end else begin
									state_q <= S_TG_HOLD;
								end
							end
							default: begin
								// tick and stop both need the last key
								addr_q  <= tot_m1[KA-1:0];
								state_q <= S_LAST_WAIT;
							end
						endcase
					end
				end

				// insertion: shift later keys up one slot
				S_ADD_CHK: begin
					if (idx_q == '0) begin
						key_total_q <= key_total_q + 1'b1;
						state_q     <= S_OUT;
					end else begin
						addr_q  <= KA'(idx_q - 1'b1);
						state_q <= S_ADD_WAIT;
					end
				end
				S_ADD_WAIT: state_q <= S_ADD_USE;
				S_ADD_USE: begin
					if (rd_tm_q > ktime_q) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_ADD_CHK;
					end else begin
						key_total_q <= key_total_q + 1'b1;
						state_q     <= S_OUT;
					end
				end

				// last key: duration and rest level
				S_LAST_WAIT: state_q <= S_LAST_USE;
				S_LAST_USE: begin
					last_tm_q <= tbl_empty ? '0 : rd_tm_q;
					last_lv_q <= tbl_empty ? '0 : rd_lv_q;
					if (cmd_q == kfenv_pkg::CMD_STOP) begin
						for (int v = 0; v < VOICE_COUNT; v++) begin
							v_act_q[v]   <= 1'b0;
							v_fresh_q[v] <= 1'b0;
							v_now_q[v]   <= '0;
							v_bef_q[v]   <= '0;
						end
						holding_q   <= 1'b0;
						held_q      <= '0;
						out_level_q <= tbl_empty ? '0 : rd_lv_q;
						state_q     <= S_OUT;
					end else begin
						vi_q    <= '0;
						acc_q   <= '0;
						any_q   <= 1'b0;
						state_q <= S_TK_VOICE;
					end
				end

				// overlap trigger: first free voice, else the furthest along
				S_TG_SCAN: begin
					if (!v_act_q[vi_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= vi_q;
					end
					if (cur_now > v_now_q[best_idx_q]) begin
						best_idx_q <= vi_q;
					end
					if (vi_q == VA'(VOICE_COUNT - 1)) begin
						state_q <= S_TG_START;
					end else begin
						vi_q <= vi_q + 1'b1;
					end
				end
				S_TG_START: begin
					v_act_q[vsel]   <= 1'b1;
					v_fresh_q[vsel] <= 1'b1;
					v_now_q[vsel]   <= amt_q;
					v_bef_q[vsel]   <= '0;
					state_q         <= S_OUT;
				end

				// restart trigger, with optional level hold
				S_TG_HOLD: begin
					if (rtrig_q == kfenv_pkg::RTRIG_HOLD && out_level_q > ca_res_q) begin
						held_q    <= out_level_q;
						holding_q <= 1'b1;
					end else begin
						holding_q <= 1'b0;
					end
					for (int v = 1; v < VOICE_COUNT; v++) begin
						v_act_q[v] <= 1'b0;
					end
					v_act_q[0]   <= 1'b1;
					v_fresh_q[0] <= 1'b1;
					v_now_q[0]   <= amt_q;
					v_bef_q[0]   <= '0;
					state_q      <= S_OUT;
				end

				// curve value at ca_t_q, returns to ret_q
				S_CA_GO: begin
					if (tbl_empty) begin
						ca_res_q <= '0;
						state_q  <= ret_q;
					end else begin
						addr_q  <= '0;
						state_q <= S_CA_W0;
					end
				end
				S_CA_W0: state_q <= S_CA_K0;
				S_CA_K0: begin
					prev_tm_q <= rd_tm_q;
					prev_lv_q <= rd_lv_q;
					if (key_total_q == KC'(1) || ca_t_q <= rd_tm_q) begin
						ca_res_q <= rd_lv_q;
						state_q  <= ret_q;
					end else begin
						i_q     <= KA'(1);
						addr_q  <= KA'(1);
						state_q <= S_CA_WI;
					end
				end
				S_CA_WI: state_q <= S_CA_KI;
				S_CA_KI: begin
					if (scan_last && ca_t_q >= rd_tm_q) begin
						ca_res_q <= rd_lv_q;
						state_q  <= ret_q;
					end else if (scan_last || ca_t_q < rd_tm_q) begin
						nxt_tm_q <= rd_tm_q;
						nxt_lv_q <= rd_lv_q;
						state_q  <= S_CA_MUL;
					end else begin
						prev_tm_q <= rd_tm_q;
						prev_lv_q <= rd_lv_q;
						i_q       <= i_q + 1'b1;
						addr_q    <= i_q + 1'b1;
						state_q   <= S_CA_WI;
					end
				end
				S_CA_MUL: begin
					if (nxt_tm_q == prev_tm_q) begin
						ca_res_q <= nxt_lv_q;
						state_q  <= ret_q;
					end else begin
						prod_q  <= dlev * $signed({1'b0, ca_t_q - prev_tm_q});
						state_q <= S_CA_DST;
					end
				end
				S_CA_DST: state_q <= S_CA_DIV;
				S_CA_DIV: begin
					if (!div_busy) begin
						ca_res_q <= interp[LW-1:0];
						state_q  <= ret_q;
					end
				end

				// tick: advance the voice
				S_TK_VOICE: begin
					if (!v_act_q[vi_q]) begin
						state_q <= S_TK_NEXT;
					end else begin
						if (v_fresh_q[vi_q]) begin
							v_fresh_q[vi_q] <= 1'b0;
						end else begin
							v_bef_q[vi_q] <= cur_now;
							v_now_q[vi_q] <= now_sat;
						end
						state_q <= S_TK_PK;
					end
				end
				S_TK_PK: begin
					pk_lo_q <= (cur_now < cur_bef) ? cur_now : cur_bef;
					pk_hi_q <= (cur_now < cur_bef) ? cur_bef : cur_now;
					ca_t_q  <= (cur_now < cur_bef) ? cur_now : cur_bef;
					ret_q   <= S_PK_A;
					state_q <= S_CA_GO;
				end
				S_PK_A: begin
					peak_q  <= ca_res_q;
					ca_t_q  <= pk_hi_q;
					ret_q   <= S_PK_B;
					state_q <= S_CA_GO;
				end
				S_PK_B: begin
					if (ca_res_q > peak_q) begin
						peak_q <= ca_res_q;
					end
					if (tbl_empty) begin
						state_q <= S_TK_ACC;
					end else begin
						i_q     <= '0;
						addr_q  <= '0;
						state_q <= S_PK_WAIT;
					end
				end
				S_PK_WAIT: state_q <= S_PK_SCAN;
				// keys strictly inside the span
				S_PK_SCAN: begin
					if (rd_tm_q > pk_lo_q && rd_tm_q < pk_hi_q && rd_lv_q > peak_q) begin
						peak_q <= rd_lv_q;
					end
					if (scan_last) begin
						state_q <= S_TK_ACC;
					end else begin
						i_q     <= i_q + 1'b1;
						addr_q  <= i_q + 1'b1;
						state_q <= S_PK_WAIT;
					end
				end
				S_TK_ACC: begin
					if (blend_q == kfenv_pkg::BLEND_SUM) begin
						acc_q <= acc_sum;
					end else if (!any_q || peak_ext > acc_q) begin
						acc_q <= peak_ext;
					end
					any_q <= 1'b1;
					if (cur_now >= last_tm_q) begin
						v_act_q[vi_q] <= 1'b0;
					end
					state_q <= S_TK_NEXT;
				end
				S_TK_NEXT: begin
					if (vi_q == VA'(VOICE_COUNT - 1)) begin
						state_q <= S_TK_FIN;
					end else begin
						vi_q    <= vi_q + 1'b1;
						state_q <= S_TK_VOICE;
					end
				end
				S_TK_FIN: begin
					if (holding_q && blend_lvl < held_q) begin
						out_level_q <= held_q;
					end else begin
						out_level_q <= blend_lvl;
						holding_q   <= 1'b0;
					end
					state_q <= S_OUT;
				end

				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// channel outputs
	assign in_ch.ready     = state_q == S_IDLE;
	assign out_ch.valid    = state_q == S_OUT;
	assign out_ch.level    = out_level_q;
	assign out_ch.accepted = ok_q;
	assign out_ch.playing  = playing;

endmodule
